// File: rtl/core/hbe_pkg.sv
// Shared types and constants of the histogram binning engine.
package hbe_pkg;

    // Q16.16 sample and grid value.
    typedef logic signed [31:0] q16_t;

    // Command field of an input transfer.
    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_ADD   = 2'd0;
    localparam cmd_t CMD_CLEAR = 2'd1;
    localparam cmd_t CMD_DUMP  = 2'd2;

    // Configuration register indexes (byte address is four times the index).
    typedef logic [1:0] reg_idx_t;

    localparam reg_idx_t REG_RANGE_LOW  = 2'd0;
    localparam reg_idx_t REG_RANGE_HIGH = 2'd1;
    localparam reg_idx_t REG_BINS       = 2'd2;
    localparam reg_idx_t REG_DROP_UPPER = 2'd3;

    // Widths of the shared restoring divider: remainder, dividend/quotient shifter and step counter.
    localparam int REM_W  = 34;
    localparam int QUO_W  = 34;
    localparam int DCNT_W = 6;

endpackage

// File: rtl/core/hbe_in_if.sv
// Input channel of the histogram binning engine: command and sample.
interface hbe_in_if
    import hbe_pkg::*;
();
    logic valid;
    logic ready;
    cmd_t command;
    q16_t sample;

    modport source (output valid, output command, output sample, input ready);
    modport sink   (input valid, input command, input sample, output ready);
endinterface

// File: rtl/core/hbe_out_if.sv
// Output channel of the histogram binning engine: one bin per transfer.
interface hbe_out_if
    import hbe_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [5:0]  bin_index;
    q16_t        bin_grid_value;
    logic [31:0] bin_count;
    logic        last_bin;

    modport source (output valid, output bin_index, output bin_grid_value,
                    output bin_count, output last_bin, input ready);
    modport sink   (input valid, input bin_index, input bin_grid_value,
                    input bin_count, input last_bin, output ready);
endinterface

// File: rtl/core/hbe_ram.sv
// Generic single-clock RAM with one write port and a registered read port.
module hbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read; the read data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/histogram_binning_engine.sv
// Top level of the histogram binning engine: control, divider, count store access.
//
//  Channel   Direction  Handshake              Carries
//  in_ch     in         valid/ready            command, sample
//  out_ch    out        valid/ready            bin_index, bin_grid_value, bin_count, last_bin
//  APB       in         psel/penable/pready    range_low, range_high, bins_in_use, drop_upper_edge
//
// A counted add runs the range test, numerator setup, the restoring divider (one quotient
// bit per cycle), a count read and write; an ignored sample ends after the range test. A
// clear writes zero to every entry. A dump runs a grid setup (a 34-bit quotient from the same
// divider), then per bin a memory read and an output load; a stalled output holds the dump.
// After reset a clearing pass writes zero to all MAX_BINS entries, during which no
// input transfer is taken; configuration writes are taken at all times.
module histogram_binning_engine
    import hbe_pkg::*;
#(
    parameter int MAX_BINS    = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    hbe_in_if.sink      in_ch,
    hbe_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int BB    = $clog2(MAX_BINS);
    localparam int CNT_W = $clog2(MAX_BINS + 1);
    localparam int NUM_W = 34 + BB;
    localparam int QSH   = QUO_W - BB;

    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_ACHK = 4'd2;
    localparam logic [3:0] ST_ANUM = 4'd3;
    localparam logic [3:0] ST_ADIV = 4'd4;
    localparam logic [3:0] ST_ARD  = 4'd5;
    localparam logic [3:0] ST_AWR  = 4'd6;
    localparam logic [3:0] ST_GDIV = 4'd7;
    localparam logic [3:0] ST_GFIX = 4'd8;
    localparam logic [3:0] ST_DRD  = 4'd9;
    localparam logic [3:0] ST_DOUT = 4'd10;

    // Configuration registers.
    q16_t       lo_reg;
    q16_t       hi_reg;
    logic [6:0] bins_reg;
    logic       drop_reg;

    // Control registers.
    logic [3:0]    state_reg, state_next;
    logic [BB-1:0] idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;

    // Datapath registers.
    q16_t                   sample_reg, sample_next;
    logic [31+BB:0]         prod_reg, prod_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [QUO_W-1:0]       quo_reg, quo_next;
    logic [REM_W-1:0]       div_reg, div_next;
    logic [DCNT_W-1:0]      dcnt_reg, dcnt_next;
    logic                   span_neg_reg, span_neg_next;
    logic signed [QUO_W:0]  q_step_reg, q_step_next;
    logic [BB:0]            r_step_reg, r_step_next;
    logic signed [QUO_W:0]  q_acc_reg, q_acc_next;
    logic [BB:0]            r_acc_reg, r_acc_next;
    logic [5:0]             out_index_reg, out_index_next;
    q16_t                   out_grid_reg, out_grid_next;
    logic [31:0]            out_count_reg, out_count_next;
    logic                   out_last_reg, out_last_next;

    // Count store access.
    logic                   ram_wr_en;
    logic                   ram_rd_en;
    logic [BB-1:0]          ram_addr;
    logic [COUNT_WIDTH-1:0] ram_wr_data;
    logic [COUNT_WIDTH-1:0] ram_rd_data;

    // Combinational helpers.
    logic [CNT_W-1:0]   eff_bins;
    logic [BB-1:0]      bm1;
    logic [BB:0]        dvsr;
    logic signed [32:0] span33;
    logic signed [32:0] diff33;
    logic [33:0]        two_span;
    logic [33:0]        span_mag;
    logic               counted;
    logic [NUM_W-1:0]   num;
    logic [REM_W-1:0]   trial;
    logic               trial_ge;
    logic [BB+1:0]      r_sum;
    logic               carry;
    logic [BB:0]        r0;
    logic               slot_free;
    logic               cfg_wr;

    // Effective bin count clamped to the supported range.
    always_comb
    begin
        if (32'(bins_reg) < 32'd2)
        begin
            eff_bins = CNT_W'(2);
        end
        else if (32'(bins_reg) > 32'(MAX_BINS))
        begin
            eff_bins = CNT_W'(MAX_BINS);
        end
        else
        begin
            eff_bins = CNT_W'(bins_reg);
        end
    end

    assign bm1  = BB'(eff_bins - CNT_W'(1));
    assign dvsr = {bm1, 1'b0};

    // Range arithmetic on the configured bounds and the held sample.
    assign span33   = {hi_reg[31], hi_reg} - {lo_reg[31], lo_reg};
    assign diff33   = {sample_reg[31], sample_reg} - {lo_reg[31], lo_reg};
    assign two_span = {span33, 1'b0};
    assign span_mag = two_span[33] ? (~two_span + 34'd1) : two_span;
    assign counted  = (hi_reg > lo_reg) && (sample_reg >= lo_reg) && (sample_reg <= hi_reg)
                      && !((sample_reg == hi_reg) && drop_reg);
    assign num      = NUM_W'({prod_reg, 1'b0}) + NUM_W'(span33[31:0]);

    // One restoring division step.
    assign trial    = {rem_reg[REM_W-2:0], quo_reg[QUO_W-1]};
    assign trial_ge = (trial >= div_reg);

    // Incremental grid remainder step.
    assign r_sum = {1'b0, r_acc_reg} + {1'b0, r_step_reg};
    assign carry = (r_sum >= {1'b0, dvsr});
    assign r0    = rem_reg[BB:0];

    assign slot_free = !out_valid_reg || out_ch.ready;

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        sample_next    = sample_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_next       = div_reg;
        dcnt_next      = dcnt_reg;
        span_neg_next  = span_neg_reg;
        q_step_next    = q_step_reg;
        r_step_next    = r_step_reg;
        q_acc_next     = q_acc_reg;
        r_acc_next     = r_acc_reg;
        out_index_next = out_index_reg;
        out_grid_next  = out_grid_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;
        ram_addr       = idx_reg;
        ram_wr_data    = '0;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLR:
            begin
                ram_wr_en = 1'b1;
                if (idx_reg == BB'(MAX_BINS - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + BB'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    case (in_ch.command)
                        CMD_ADD:
                        begin
                            sample_next = in_ch.sample;
                            state_next  = ST_ACHK;
                        end
                        CMD_CLEAR:
                        begin
                            idx_next   = '0;
                            state_next = ST_CLR;
                        end
                        CMD_DUMP:
                        begin
                            rem_next      = '0;
                            quo_next      = QUO_W'(span_mag);
                            div_next      = REM_W'(dvsr);
                            dcnt_next     = DCNT_W'(QUO_W);
                            span_neg_next = span33[32];
                            state_next    = ST_GDIV;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ACHK:
            begin
                // Range test, then scale the offset by the last bin index.
                if (counted)
                begin
                    prod_next  = (32 + BB)'(diff33[31:0]) * (32 + BB)'(bm1);
                    state_next = ST_ANUM;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ANUM:
            begin
                // The quotient fits in BB bits, so only those bits are iterated.
                rem_next   = REM_W'(num >> BB);
                quo_next   = QUO_W'(num[BB-1:0]) << QSH;
                div_next   = REM_W'({span33[31:0], 1'b0});
                dcnt_next  = DCNT_W'(BB);
                state_next = ST_ADIV;
            end
            ST_ADIV, ST_GDIV:
            begin
                rem_next  = trial_ge ? (trial - div_reg) : trial;
                quo_next  = {quo_reg[QUO_W-2:0], trial_ge};
                dcnt_next = dcnt_reg - DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(1))
                begin
                    state_next = (state_reg == ST_ADIV) ? ST_ARD : ST_GFIX;
                end
            end
            ST_ARD:
            begin
                ram_rd_en  = 1'b1;
                ram_addr   = quo_reg[BB-1:0];
                state_next = ST_AWR;
            end
            ST_AWR:
            begin
                // Saturating increment of the bin read in the previous cycle.
                ram_wr_en   = 1'b1;
                ram_addr    = quo_reg[BB-1:0];
                ram_wr_data = (ram_rd_data == '1) ? ram_rd_data : ram_rd_data + 1'b1;
                state_next  = ST_IDLE;
            end
            ST_GFIX:
            begin
                // Turn the magnitude quotient into a floored step and remainder.
                if (span_neg_reg && (r0 != '0))
                begin
                    q_step_next = -((QUO_W + 1)'(quo_reg) + (QUO_W + 1)'(1));
                    r_step_next = dvsr - r0;
                end
                else if (span_neg_reg)
                begin
                    q_step_next = -((QUO_W + 1)'(quo_reg));
                    r_step_next = '0;
                end
                else
                begin
                    q_step_next = (QUO_W + 1)'(quo_reg);
                    r_step_next = r0;
                end
                q_acc_next = '0;
                r_acc_next = {1'b0, bm1};
                idx_next   = '0;
                state_next = ST_DRD;
            end
            ST_DRD:
            begin
                ram_rd_en  = 1'b1;
                state_next = ST_DOUT;
            end
            ST_DOUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = 6'(idx_reg);
                    out_grid_next  = lo_reg + q16_t'(q_acc_reg[31:0]);
                    out_count_next = 32'(ram_rd_data);
                    out_last_next  = (idx_reg == bm1);
                    r_acc_next     = carry ? (BB + 1)'(r_sum - {1'b0, dvsr}) : r_sum[BB:0];
                    q_acc_next     = q_acc_reg + q_step_reg + (QUO_W + 1)'(carry);
                    if (idx_reg == bm1)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + BB'(1);
                        state_next = ST_DRD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state; reset starts the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        sample_reg    <= sample_next;
        prod_reg      <= prod_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        div_reg       <= div_next;
        dcnt_reg      <= dcnt_next;
        span_neg_reg  <= span_neg_next;
        q_step_reg    <= q_step_next;
        r_step_reg    <= r_step_next;
        q_acc_reg     <= q_acc_next;
        r_acc_reg     <= r_acc_next;
        out_index_reg <= out_index_next;
        out_grid_reg  <= out_grid_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
    end

    // Configuration register writes.
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg   <= 32'sd0;
            hi_reg   <= 32'sd65536;
            bins_reg <= 7'd2;
            drop_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_RANGE_LOW:  lo_reg   <= pwdata;
                REG_RANGE_HIGH: hi_reg   <= pwdata;
                REG_BINS:       bins_reg <= pwdata[6:0];
                REG_DROP_UPPER: drop_reg <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // Configuration register reads.
    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_RANGE_LOW:  prdata = lo_reg;
            REG_RANGE_HIGH: prdata = hi_reg;
            REG_BINS:       prdata = {25'd0, bins_reg};
            REG_DROP_UPPER: prdata = {31'd0, drop_reg};
            default:        prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Count store.
    hbe_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (MAX_BINS)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_addr),
        .rd_data (ram_rd_data)
    );

    // Channel outputs.
    assign in_ch.ready           = (state_reg == ST_IDLE);
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.bin_index      = out_index_reg;
    assign out_ch.bin_grid_value = out_grid_reg;
    assign out_ch.bin_count      = out_count_reg;
    assign out_ch.last_bin       = out_last_reg;

`ifndef ASSERT_OFF
    // The count store is used as a single port: never a read and a write together.
    assert property (@(posedge clk) disable iff (!rst_n) !(ram_rd_en && ram_wr_en))
        else $error("count store read and written in the same cycle");

    // The increment write follows directly on its own read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_AWR) |-> ($past(state_reg) == ST_ARD))
        else $error("count write without a preceding read");

    // The divider remainder stays below the divisor while iterating.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_ADIV) || (state_reg == ST_GDIV)) |-> (rem_reg < div_reg))
        else $error("divider remainder out of range");

    // A counted sample lands in a bin in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ARD) |-> (quo_reg <= QUO_W'(bm1)))
        else $error("bin index beyond the last bin");
`endif

endmodule
